[sv/rcpd_pkg.sv]
// ----------------------------------------------------------------------------
// rcpd_pkg
// Shared widths, constants and register codes of the RC pulse decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpd_pkg;

    // timestamp arithmetic width, default
    localparam int TIME_BITS_DEF = 32;

    // field widths
    localparam int TIME_US_W = 32;
    localparam int NOISE_W   = 10;
    localparam int DZ_W      = 9;
    localparam int PW_W      = 11;
    localparam int POS_W     = 10;

    // clamped working width of a measured pulse
    localparam int WID_W = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    // register reset values
    localparam logic [NOISE_W-1:0] NOISE_RST  = NOISE_W'(100);
    localparam logic [DZ_W-1:0]    EDGE_RST   = DZ_W'(50);
    localparam logic [DZ_W-1:0]    CENTER_RST = DZ_W'(45);

    // pulse width landmarks, us
    localparam logic [WID_W-1:0] WIDTH_TOP    = WID_W'(2000);
    localparam logic [WID_W-1:0] WIDTH_BOTTOM = WID_W'(1000);
    localparam logic [WID_W-1:0] WIDTH_CENTER = WID_W'(1500);

    // register word index (byte address / 4)
    typedef enum logic [1:0] {
        REG_NOISE  = 2'd0,
        REG_EDGE   = 2'd1,
        REG_CENTER = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

[sv/rcpd_if.sv]
// ----------------------------------------------------------------------------
// rcpd_in_if / rcpd_out_if
// Valid/ready channels for pin samples and for decoded pulse results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpd_in_if
    import rcpd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 level;
    logic [TIME_US_W-1:0] time_us;

    modport source (output valid, output level, output time_us, input ready);
    modport sink   (input valid, input level, input time_us, output ready);
endinterface

interface rcpd_out_if
    import rcpd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [PW_W-1:0]         pulse_width;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output pulse_width, output position, input ready);
    modport sink   (input valid, input pulse_width, input position, output ready);
endinterface

`default_nettype wire

[sv/rc_pwm_pulse_decoder_unit.sv]
// ----------------------------------------------------------------------------
// rc_pwm_pulse_decoder_unit
// A result passes through the input register and then the result register
// before it can transfer. Throughput: one sample per cycle while the result
// channel is not stalled; under back-pressure s1 fills only while empty.
// Reset (rst_n low, async): both stages empty, pin taken as low, rise time 0,
// registers at noise floor 100, edge dead zone 50, center dead zone 45.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pwm_pulse_decoder_unit
    import rcpd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    // configuration port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [CFG_ADDR_W-1:0]   paddr,
    input  wire [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    // channels
    rcpd_in_if.sink                in_ch,
    rcpd_out_if.source             out_ch
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NOISE_W-1:0] noise_reg;
    logic [DZ_W-1:0]    edge_dz_reg;
    logic [DZ_W-1:0]    center_dz_reg;
    cfg_reg_t           cfg_sel;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg     <= NOISE_RST;
            edge_dz_reg   <= EDGE_RST;
            center_dz_reg <= CENTER_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_NOISE:  noise_reg     <= pwdata[NOISE_W-1:0];
                REG_EDGE:   edge_dz_reg   <= pwdata[DZ_W-1:0];
                REG_CENTER: center_dz_reg <= pwdata[DZ_W-1:0];
                default:    ; // unmapped word, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_NOISE:  prdata = CFG_DATA_W'(noise_reg);
            REG_EDGE:   prdata = CFG_DATA_W'(edge_dz_reg);
            REG_CENTER: prdata = CFG_DATA_W'(center_dz_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic                 s1_level_reg;
    logic [TIME_US_W-1:0] s1_time_reg;
    logic                 s1_adv;
    logic                 in_xfer;

    // result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [PW_W-1:0]         out_pw_reg;
    logic signed [POS_W-1:0] out_pos_reg;

    // s1 moves on whenever the result register is free or draining
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_adv;
    assign in_xfer      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_level_reg <= in_ch.level;
            s1_time_reg  <= in_ch.time_us;
        end
    end

    // ------------------------------------------------------------------
    // Edge state: last pin level and time of the last rising edge
    // ------------------------------------------------------------------
    logic                 last_level_reg;
    logic [TIME_BITS-1:0] rise_time_reg;
    logic [TIME_BITS-1:0] now;
    logic                 level_change;

    assign now          = TIME_BITS'(s1_time_reg);
    assign level_change = s1_level_reg != last_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            rise_time_reg  <= '0;
        end
        else if (s1_adv && level_change)
        begin
            last_level_reg <= s1_level_reg;
            if (s1_level_reg)
                rise_time_reg <= now;
        end
    end

    // ------------------------------------------------------------------
    // Width measurement and dead-zone snapping
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0]    diff;
    logic                    diff_neg;
    logic                    diff_big;
    logic [WID_W-1:0]        w_clamp;
    logic                    too_short;
    logic                    hit;
    logic [WID_W-1:0]        top_thr;
    logic [WID_W-1:0]        bot_thr;
    logic [WID_W-1:0]        w_top;
    logic [WID_W-1:0]        w_bot;
    logic signed [WID_W:0]   off;
    logic [WID_W:0]          off_abs;
    logic [WID_W-1:0]        w_ctr;
    logic [WID_W-1:0]        w_fin;
    logic [WID_W-1:0]        pos_wide;

    assign diff     = now - rise_time_reg;          // wraps mod 2^TIME_BITS
    assign diff_neg = diff[TIME_BITS-1];
    assign diff_big = (diff >> WID_W) != '0;
    // clamp far above every snap point
    assign w_clamp  = diff_big ? {WID_W{1'b1}} : diff[WID_W-1:0];
    assign too_short = w_clamp < WID_W'(noise_reg);

    // a result only on a falling edge with a plausible width
    assign hit = level_change && !s1_level_reg && !diff_neg && !too_short;

    assign top_thr = WIDTH_TOP - WID_W'(edge_dz_reg);
    assign bot_thr = WIDTH_BOTTOM + WID_W'(edge_dz_reg);

    assign w_top   = (w_clamp >= top_thr) ? WIDTH_TOP : w_clamp;
    assign w_bot   = (w_top <= bot_thr) ? WIDTH_BOTTOM : w_top;

    assign off     = $signed({1'b0, w_bot}) - $signed({1'b0, WIDTH_CENTER});
    assign off_abs = off[WID_W] ? (WID_W+1)'(-off) : (WID_W+1)'(off);
    assign w_ctr   = (off_abs <= (WID_W+1)'(center_dz_reg)) ? WIDTH_CENTER : w_bot;

    // final saturation to the legal servo range
    always_comb
    begin
        if (w_ctr > WIDTH_TOP)
            w_fin = WIDTH_TOP;
        else if (w_ctr < WIDTH_BOTTOM)
            w_fin = WIDTH_BOTTOM;
        else
            w_fin = w_ctr;
    end

    assign pos_wide = w_fin - WIDTH_CENTER;

    // ------------------------------------------------------------------
    // Stage 2: result register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s1_adv)
            out_valid_next = hit;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && hit)
        begin
            out_pw_reg  <= w_fin[PW_W-1:0];
            out_pos_reg <= $signed(pos_wide[POS_W-1:0]);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pulse_width = out_pw_reg;
    assign out_ch.position    = out_pos_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // results stay inside the servo range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pw_reg >= PW_W'(1000)) && (out_pw_reg <= PW_W'(2000)))
        else $error("pulse_width out of range");

    // position tracks the width about center
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pos_reg == $signed(POS_W'(out_pw_reg - PW_W'(1500)))))
        else $error("position inconsistent with pulse_width");

    // a rising edge never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_level_reg) |=> !out_valid_reg)
        else $error("result emitted on rising edge");

    // a processed rising edge records its timestamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && level_change && s1_level_reg) |=> (rise_time_reg == $past(now)))
        else $error("rise time not captured");

endmodule

`default_nettype wire

[tb/sv/rcpd_checker.sv]
// ----------------------------------------------------------------------------
// rcpd_checker
// Monitors the config port and both channels of the RC pulse decoder. It
// keeps a shadow copy of the registers and the pin state, works out the
// decoded pulse for every sample transfer, and checks each result transfer
// in order. Register reads are checked against the shadow copy.
// ----------------------------------------------------------------------------
module rcpd_checker
    import rcpd_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [CFG_ADDR_W-1:0] paddr,
    input  wire [CFG_DATA_W-1:0] pwdata,
    input  wire [CFG_DATA_W-1:0] prdata,
    input  wire                  pready,
    rcpd_in_if                   in_mon,
    rcpd_out_if                  out_mon,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int CLAMP_US    = 65535;

    typedef struct {
        logic [PW_W-1:0]         pw;
        logic signed [POS_W-1:0] pos;
    } pulse_t;

    pulse_t               pulse_q[$];
    logic [NOISE_W-1:0]   noise_thr;
    logic [DZ_W-1:0]      edge_dz;
    logic [DZ_W-1:0]      center_dz;
    logic                 pin_level;
    logic [TIME_US_W-1:0] rise_at;
    int                   err_cnt;

    task automatic flag(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%t rcpd_checker: %s", $realtime, msg);
    endtask

    // one pin sample: edge detect, width measure, dead-zone snapping
    task automatic decode_sample(input logic lvl, input logic [TIME_US_W-1:0] t);
        logic [TIME_US_W-1:0] span;
        int                   w;
        int                   off;
        pulse_t               res;
        if (lvl == pin_level)
            return;
        pin_level = lvl;
        if (lvl) begin
            rise_at = t;
            return;
        end
        span = t - rise_at;
        if (span[TIME_US_W-1])
            return;                                 // falling before rising
        if (span < TIME_US_W'(noise_thr))
            return;
        if (span > TIME_US_W'(CLAMP_US))
            span = TIME_US_W'(CLAMP_US);
        w = int'(span);
        if (w >= int'(WIDTH_TOP) - int'(edge_dz))
            w = int'(WIDTH_TOP);
        if (w <= int'(WIDTH_BOTTOM) + int'(edge_dz))
            w = int'(WIDTH_BOTTOM);
        off = w - int'(WIDTH_CENTER);
        if (off < 0)
            off = -off;
        if (off <= int'(center_dz))
            w = int'(WIDTH_CENTER);
        if (w > int'(WIDTH_TOP))
            w = int'(WIDTH_TOP);
        if (w < int'(WIDTH_BOTTOM))
            w = int'(WIDTH_BOTTOM);
        res.pw  = PW_W'(w);
        res.pos = POS_W'(w - int'(WIDTH_CENTER));
        pulse_q.push_back(res);
    endtask

    task automatic check_read();
        logic [CFG_DATA_W-1:0] want;
        logic                  known;
        known = 1'b1;
        case (cfg_reg_t'(paddr[3:2]))
            REG_NOISE:  want = CFG_DATA_W'(noise_thr);
            REG_EDGE:   want = CFG_DATA_W'(edge_dz);
            REG_CENTER: want = CFG_DATA_W'(center_dz);
            default:    known = 1'b0;
        endcase
        if (known && prdata !== want)
            flag($sformatf("register read at 0x%0h: expected 0x%0h, got 0x%0h",
                           paddr, want, prdata));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pulse_t exp_p;
        if (!rst_n)
        begin
            noise_thr = NOISE_RST;
            edge_dz   = EDGE_RST;
            center_dz = CENTER_RST;
            pin_level = 1'b0;
            rise_at   = '0;
            err_cnt   = 0;
            pulse_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // results first; a sample never yields a result in its own cycle
            if (out_mon.valid && out_mon.ready)
            begin
                if (pulse_q.size() == 0)
                    flag($sformatf("unexpected result width %0d position %0d",
                                   out_mon.pulse_width, out_mon.position));
                else
                begin
                    exp_p = pulse_q.pop_front();
                    if (out_mon.pulse_width !== exp_p.pw || out_mon.position !== exp_p.pos)
                        flag($sformatf("expected width %0d pos %0d, got width %0d pos %0d",
                                       exp_p.pw, exp_p.pos,
                                       out_mon.pulse_width, out_mon.position));
                end
            end
            if (in_mon.valid && in_mon.ready)
                decode_sample(in_mon.level, in_mon.time_us);
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (cfg_reg_t'(paddr[3:2]))
                        REG_NOISE:  noise_thr = pwdata[NOISE_W-1:0];
                        REG_EDGE:   edge_dz   = pwdata[DZ_W-1:0];
                        REG_CENTER: center_dz = pwdata[DZ_W-1:0];
                        default:    ;
                    endcase
                end
                else
                    check_read();
            end
            errors  <= err_cnt;
            pending <= pulse_q.size();
        end
    end

endmodule

[tb/sv/tb_rc_pwm_pulse_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_rc_pwm_pulse_decoder_unit
// Drives pin samples and register settings into the RC pulse decoder and
// lets rcpd_checker predict and compare every decoded pulse. A directed
// opening covers the landmarks and corner cases, then random pulse trains
// run under several register settings with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_rc_pwm_pulse_decoder_unit
    import rcpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int MAX_GAP       = 11;
    localparam int SETTLE_CYCLES = 4;       // pipeline is two deep
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RUN_LIMIT_NS  = 8_000_000;
    localparam int REG_STRIDE    = 4;
    localparam int SPARE_REG_IDX = 3;       // first index past the register list
    localparam int PHASES        = 6;
    localparam int EDGES_PER_PH  = 280;     // counted in pin changes
    localparam int IDLE_SWAP     = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    errors;
    int                    pending;

    rcpd_in_if  in_ch();
    rcpd_out_if out_ch();

    // idling switches, flipped independently to get stretches with none
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;

    // stimulus-side view of the pin and of the current register values
    logic               pin;
    int                 edges_sent;
    logic [NOISE_W-1:0] cur_noise;
    logic [DZ_W-1:0]    cur_edge;
    logic [DZ_W-1:0]    cur_center;

    always #(CLK_HALF) clk = ~clk;

    rc_pwm_pulse_decoder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    rcpd_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    // ------------------------------------------------------------------------
    // Sample channel. valid stays high across back-to-back transfers, dropped
    // only for a drawn gap or a drain, so it never sees two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic lvl, input logic [TIME_US_W-1:0] t);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.level   <= lvl;
        in_ch.time_us <= t;
        do @(posedge clk); while (!in_ch.ready);
        if (lvl != pin)
            edges_sent++;
        pin = lvl;
    endtask

    // one high pulse; the width wraps like the timestamp does
    task automatic pulse(input logic [TIME_US_W-1:0] rise_t, input logic [TIME_US_W-1:0] width);
        send_sample(1'b1, rise_t);
        send_sample(1'b0, rise_t + width);
    endtask

    // Stop sending and wait for every pending result to be transferred (up to
    // DRAIN_LIMIT), then idle for samples still in the pipe that decode to nothing.
    task automatic drain();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup + access, then idle with psel low so a following access starts clean
    task automatic apb_xfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write then read back; the checker compares the read data
    task automatic set_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        logic [CFG_ADDR_W-1:0] addr;
        addr = CFG_ADDR_W'(int'(r) * REG_STRIDE);
        apb_xfer(1'b1, addr, v);
        apb_xfer(1'b0, addr, '0);
        case (r)
            REG_NOISE:  cur_noise  = v[NOISE_W-1:0];
            REG_EDGE:   cur_edge   = v[DZ_W-1:0];
            REG_CENTER: cur_center = v[DZ_W-1:0];
            default:    ;
        endcase
    endtask

    // Widths weighted toward the snap points of the current setting, with
    // plain stick travel, short glitches and wild values mixed in.
    function automatic logic [TIME_US_W-1:0] pick_width();
        int sel;
        int mark;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return TIME_US_W'($urandom_range(900, 2100));
        if (sel < 65)
        begin
            case ($urandom_range(0, 4))
                0:       mark = int'(WIDTH_BOTTOM) + int'(cur_edge);
                1:       mark = int'(WIDTH_TOP) - int'(cur_edge);
                2:       mark = int'(WIDTH_CENTER) + int'(cur_center);
                3:       mark = int'(WIDTH_CENTER) - int'(cur_center);
                default: mark = int'(cur_noise);
            endcase
            return TIME_US_W'(mark + int'($urandom_range(0, 4)) - 2);
        end
        if (sel < 80)
            return TIME_US_W'($urandom_range(0, 1100));
        if (sel < 90)
            return $urandom();
        return TIME_US_W'($urandom_range(1, 1_000_000));
    endfunction

    // Mostly clean pulses; the rest are backward timestamps, repeated
    // levels and lone edges that break the rise/fall pairing.
    task automatic random_item();
        int                   sel;
        logic [TIME_US_W-1:0] t0;
        sel = $urandom_range(0, 99);
        t0  = $urandom();
        if (sel < 75)
            pulse(t0, pick_width());
        else if (sel < 82)
        begin
            send_sample(1'b1, t0);
            send_sample(1'b0, t0 - TIME_US_W'($urandom_range(1, 5000)));
        end
        else if (sel < 92)
            send_sample(pin, t0);
        else
            send_sample(1'($urandom_range(0, 1)), t0);
    endtask

    // ------------------------------------------------------------------------
    // Result channel: a drawn stall before each transfer, none when sink_idle
    // is off.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int goal;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.level   = 1'b0;
        in_ch.time_us = '0;
        pin           = 1'b0;
        edges_sent    = 0;
        cur_noise     = NOISE_RST;
        cur_edge      = EDGE_RST;
        cur_center    = CENTER_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values read back
        apb_xfer(1'b0, CFG_ADDR_W'(int'(REG_NOISE) * REG_STRIDE), '0);
        apb_xfer(1'b0, CFG_ADDR_W'(int'(REG_EDGE) * REG_STRIDE), '0);
        apb_xfer(1'b0, CFG_ADDR_W'(int'(REG_CENTER) * REG_STRIDE), '0);

        // -------- directed, reset settings: noise 100, edge 50, center 45 --
        send_sample(1'b0, '0);                  // low after reset: no edge
        pulse(32'd1000, 32'd1500);              // dead center
        pulse(32'd0, 32'd2000);                 // top
        pulse(32'd3000, 32'd1000);              // bottom
        pulse(32'd10000, 32'd99);               // one short of noise floor
        pulse(32'd20000, 32'd100);              // right at noise floor
        send_sample(1'b1, 32'd30000);
        send_sample(1'b1, 32'd30500);           // level held high, ignored
        send_sample(1'b0, 32'd31700);
        send_sample(1'b1, 32'd50000);
        send_sample(1'b0, 32'd49000);           // fall stamped before rise
        pulse(32'hFFFF_FF00, 32'd1300);         // timestamp wraps mid-pulse
        pulse(32'd0, 32'h7FFF_FFFF);            // longest positive width
        pulse(32'd5, 32'h8000_0000);            // reads as negative
        pulse(32'd100000, 32'd1545);            // inside center band
        pulse(32'd200000, 32'd1546);            // just outside it
        pulse(32'd300000, 32'd1950);            // edge band, top side
        pulse(32'hFFFF_FFFF, 32'd1949);
        pulse(32'd400000, 32'd1051);            // just above bottom band

        // mid-stream pause until everything is out
        drain();

        // -------- random phases, each under its own register setting --------
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    set_reg(REG_NOISE, '0);
                    set_reg(REG_EDGE, '0);
                    set_reg(REG_CENTER, '0);
                end
                1:
                begin
                    set_reg(REG_NOISE, CFG_DATA_W'(1000));
                    set_reg(REG_EDGE, CFG_DATA_W'(400));
                    set_reg(REG_CENTER, CFG_DATA_W'(400));
                end
                2:
                begin
                    // beyond the stated ranges; upper pwdata bits dropped
                    set_reg(REG_NOISE, '1);
                    set_reg(REG_EDGE, '1);
                    set_reg(REG_CENTER, '1);
                end
                3:
                begin
                    set_reg(REG_NOISE, CFG_DATA_W'(NOISE_RST));
                    set_reg(REG_EDGE, CFG_DATA_W'(EDGE_RST));
                    set_reg(REG_CENTER, CFG_DATA_W'(CENTER_RST));
                    // write past the register list must not disturb anything
                    apb_xfer(1'b1, CFG_ADDR_W'(SPARE_REG_IDX * REG_STRIDE), '1);
                end
                default:
                begin
                    set_reg(REG_NOISE, CFG_DATA_W'($urandom_range(0, 1000)));
                    set_reg(REG_EDGE, CFG_DATA_W'($urandom_range(0, 400)));
                    set_reg(REG_CENTER, CFG_DATA_W'($urandom_range(0, 400)));
                end
            endcase

            goal = edges_sent + EDGES_PER_PH;
            while (edges_sent < goal)
            begin
                if (edges_sent % IDLE_SWAP == 0)
                begin
                    src_idle  = ($urandom_range(0, 3) != 0);
                    sink_idle = ($urandom_range(0, 3) != 0);
                end
                random_item();
            end
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("tb_rc_pwm_pulse_decoder_unit: clean");
        else
            $display("tb_rc_pwm_pulse_decoder_unit: errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_rc_pwm_pulse_decoder_unit: errors");
        $finish;
    end

endmodule
